// File: rtl/core/lojd_pkg.sv
// shared types and constants for the label overlap scorer
package lojd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int THRESH_W    = 16;
    localparam int RATIO_W     = 17;
    localparam int RATIO_F     = 16;
    localparam int TOTAL_W     = 32;
    localparam int DIV_QW      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FUZZY_MODE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPORT_DICE = 2'd2;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd32768;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_EMPTY       = 2'd1;
    localparam logic [1:0] STATUS_ZERO_VOLUME = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic                end_of_volume;
        logic                end_of_image;
    } pair_t;

    typedef struct packed {
        logic [RATIO_W-1:0] overlap_ratio;
        logic [1:0]         status;
    } score_t;

endpackage

// File: rtl/core/lojd_div.sv
// bit-serial fractional divider: round(num * 2^frac_bits / den), clamped to one
module lojd_div #(
    parameter int NW = 49,
    parameter int QW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NW-1:0]         num,
    input  logic [NW-1:0]         den,
    input  logic [$clog2(QW)-1:0] frac_bits,
    output logic [QW-1:0]         quo,
    output logic                  done
);

    localparam int CW = $clog2(QW);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t          state_reg;
    logic [NW-1:0]   rem_reg;
    logic [NW-1:0]   den_reg;
    logic [QW-1:0]   quo_reg;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;

    logic [NW:0]     rem_shift;
    logic [NW:0]     rem_sub;
    logic            fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        den_reg <= den;
                        rem_reg <= num;
                        cnt_reg <= frac_bits;
                        if (den == '0)
                        begin
                            quo_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else if (num >= den)
                        begin
                            quo_reg  <= QW'(1) << frac_bits;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            quo_reg   <= '0;
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (cnt_reg != '0)
                    begin
                        rem_reg <= fits ? rem_sub[NW-1:0] : rem_shift[NW-1:0];
                        quo_reg <= {quo_reg[QW-2:0], fits};
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                    else
                    begin
                        // round to nearest, halves up
                        if (fits)
                        begin
                            quo_reg <= quo_reg + QW'(1);
                        end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// File: rtl/core/label_overlap_jaccard_dice_core.sv
// label overlap scorer: hard jaccard / dice and fuzzy min-over-max overlap
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  pair     | pair_valid / pair_ready  | sample_a, sample_b, end_of_volume,
//           |                          | end_of_image
//  score    | score_valid / score_ready| overlap_ratio, status
//  cfg      | cfg_we                   | cfg_index, cfg_data
//
// a pair without a frame or image end leaves pair_ready high
// a frame end adds two divider runs, for the min sum and the max sum over the frame volume;
// one shared bit-serial divider does both, a zero-volume frame skips them
// an image end adds one more divider run and the S_PUSH state to load the score
// pair_ready is low while the divider works, or while a new score waits for the last one to go
// reset clears all counters, sums and totals and loads the register defaults
module label_overlap_jaccard_dice_core #(
    parameter int VOXEL_COUNT_BITS = 24,
    parameter int FRAME_COUNT_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pair_valid,
    output logic                                pair_ready,
    input  lojd_pkg::pair_t                     pair,
    output logic                                score_valid,
    input  logic                                score_ready,
    output lojd_pkg::score_t                    score,
    input  logic                                cfg_we,
    input  logic [lojd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lojd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W    = VOXEL_COUNT_BITS + 1;
    localparam int MINMAX_W = VOXEL_COUNT_BITS + lojd_pkg::SAMPLE_W;
    localparam int VOL_W    = VOXEL_COUNT_BITS + lojd_pkg::SAMPLE_W + 1;
    localparam int TERM_F   = 31 - FRAME_COUNT_BITS;
    localparam int DIV_W    = (VOL_W > lojd_pkg::TOTAL_W) ? VOL_W : lojd_pkg::TOTAL_W;
    localparam int QW       = lojd_pkg::DIV_QW;
    localparam int FW       = $clog2(QW);
    localparam int TW       = lojd_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIN_GO,
        S_MIN_WAIT,
        S_MAX_GO,
        S_MAX_WAIT,
        S_FIN_GO,
        S_FIN_WAIT,
        S_PUSH
    } state_t;

    // configuration
    logic [lojd_pkg::THRESH_W-1:0] threshold_reg;
    logic                          fuzzy_mode_reg;
    logic                          report_dice_reg;

    // accumulation state
    state_t               state_reg;
    logic [CNT_W-1:0]     count_a_reg;
    logic [CNT_W-1:0]     count_b_reg;
    logic [CNT_W-1:0]     count_both_reg;
    logic [MINMAX_W-1:0]  min_sum_reg;
    logic [MINMAX_W-1:0]  max_sum_reg;
    logic [VOL_W-1:0]     vol_sum_reg;
    logic [TW-1:0]        wmin_reg;
    logic [TW-1:0]        wmax_reg;
    logic                 zero_seen_reg;
    logic                 eoi_reg;
    logic                 score_valid_reg;
    lojd_pkg::score_t     score_reg;

    logic                 accept;
    logic                 label_a;
    logic                 label_b;
    logic [lojd_pkg::SAMPLE_W-1:0] smin;
    logic [lojd_pkg::SAMPLE_W-1:0] smax;
    logic [MINMAX_W:0]    min_sum_add;
    logic [MINMAX_W:0]    max_sum_add;
    logic [VOL_W:0]       vol_sum_add;
    logic [MINMAX_W-1:0]  min_sum_next;
    logic [MINMAX_W-1:0]  max_sum_next;
    logic [VOL_W-1:0]     vol_sum_next;
    logic [CNT_W-1:0]     count_a_next;
    logic [CNT_W-1:0]     count_b_next;
    logic [CNT_W-1:0]     count_both_next;

    logic [CNT_W:0]       sum_ab;
    logic [CNT_W:0]       union_ab;
    logic [1:0]           final_status;

    logic                 div_start;
    logic [DIV_W-1:0]     div_num;
    logic [DIV_W-1:0]     div_den;
    logic [FW-1:0]        div_frac;
    logic [QW-1:0]        div_quo;
    logic                 div_done;
    logic [TW:0]          total_add;
    logic [TW-1:0]        total_base;
    logic [TW-1:0]        total_next;
    logic                 push_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= lojd_pkg::THRESHOLD_RESET;
            fuzzy_mode_reg  <= 1'b0;
            report_dice_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lojd_pkg::REG_THRESHOLD:   threshold_reg   <= cfg_data[lojd_pkg::THRESH_W-1:0];
                lojd_pkg::REG_FUZZY_MODE:  fuzzy_mode_reg  <= cfg_data[0];
                lojd_pkg::REG_REPORT_DICE: report_dice_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign pair_ready = (state_reg == S_IDLE);
    assign accept     = pair_valid && pair_ready;

    assign label_a = pair.sample_a >= threshold_reg;
    assign label_b = pair.sample_b >= threshold_reg;
    assign smin    = (pair.sample_a < pair.sample_b) ? pair.sample_a : pair.sample_b;
    assign smax    = (pair.sample_a < pair.sample_b) ? pair.sample_b : pair.sample_a;

    assign count_a_next    = (label_a && count_a_reg != '1) ? count_a_reg + CNT_W'(1)
                                                             : count_a_reg;
    assign count_b_next    = (label_b && count_b_reg != '1) ? count_b_reg + CNT_W'(1)
                                                             : count_b_reg;
    assign count_both_next = (label_a && label_b && count_both_reg != '1)
                             ? count_both_reg + CNT_W'(1) : count_both_reg;

    // saturating frame sums
    assign min_sum_add  = {1'b0, min_sum_reg} + (MINMAX_W + 1)'(smin);
    assign max_sum_add  = {1'b0, max_sum_reg} + (MINMAX_W + 1)'(smax);
    assign vol_sum_add  = {1'b0, vol_sum_reg} + (VOL_W + 1)'(pair.sample_a)
                          + (VOL_W + 1)'(pair.sample_b);
    assign min_sum_next = min_sum_add[MINMAX_W] ? '1 : min_sum_add[MINMAX_W-1:0];
    assign max_sum_next = max_sum_add[MINMAX_W] ? '1 : max_sum_add[MINMAX_W-1:0];
    assign vol_sum_next = vol_sum_add[VOL_W] ? '1 : vol_sum_add[VOL_W-1:0];

    assign sum_ab   = {1'b0, count_a_reg} + {1'b0, count_b_reg};
    assign union_ab = sum_ab - {1'b0, count_both_reg};

    always_comb
    begin
        final_status = lojd_pkg::STATUS_OK;
        if (fuzzy_mode_reg)
        begin
            if (zero_seen_reg)
            begin
                final_status = lojd_pkg::STATUS_ZERO_VOLUME;
            end
            else if (wmax_reg == '0)
            begin
                final_status = lojd_pkg::STATUS_EMPTY;
            end
        end
        else if (union_ab == '0)
        begin
            final_status = lojd_pkg::STATUS_EMPTY;
        end
    end

    // operand select for the shared divider
    always_comb
    begin
        div_start = 1'b0;
        div_num   = DIV_W'(min_sum_reg);
        div_den   = DIV_W'(vol_sum_reg);
        div_frac  = FW'(TERM_F);
        case (state_reg)
            S_MIN_GO:
            begin
                div_start = 1'b1;
            end
            S_MAX_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_W'(max_sum_reg);
            end
            S_FIN_GO:
            begin
                div_start = 1'b1;
                div_frac  = FW'(lojd_pkg::RATIO_F);
                if (fuzzy_mode_reg)
                begin
                    div_num = DIV_W'(wmin_reg);
                    div_den = DIV_W'(wmax_reg);
                end
                else if (report_dice_reg)
                begin
                    div_num = DIV_W'({count_both_reg, 1'b0});
                    div_den = DIV_W'(sum_ab);
                end
                else
                begin
                    div_num = DIV_W'(count_both_reg);
                    div_den = DIV_W'(union_ab);
                end
            end
            default: ;
        endcase
    end

    lojd_div #(
        .NW (DIV_W),
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .num       (div_num),
        .den       (div_den),
        .frac_bits (div_frac),
        .quo       (div_quo),
        .done      (div_done)
    );

    assign total_base = (state_reg == S_MIN_WAIT) ? wmin_reg : wmax_reg;
    assign total_add  = {1'b0, total_base} + (TW + 1)'(div_quo);
    assign total_next = total_add[TW] ? '1 : total_add[TW-1:0];
    assign push_ok    = !score_valid_reg || score_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_a_reg     <= '0;
            count_b_reg     <= '0;
            count_both_reg  <= '0;
            min_sum_reg     <= '0;
            max_sum_reg     <= '0;
            vol_sum_reg     <= '0;
            wmin_reg        <= '0;
            wmax_reg        <= '0;
            zero_seen_reg   <= 1'b0;
            eoi_reg         <= 1'b0;
            score_valid_reg <= 1'b0;
            score_reg       <= '0;
        end
        else
        begin
            if (score_valid_reg && score_ready)
            begin
                score_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_a_reg    <= count_a_next;
                        count_b_reg    <= count_b_next;
                        count_both_reg <= count_both_next;
                        eoi_reg        <= pair.end_of_image;
                        if (pair.end_of_volume || pair.end_of_image)
                        begin
                            if (vol_sum_next == '0)
                            begin
                                // empty frame adds nothing to the totals
                                zero_seen_reg <= 1'b1;
                                min_sum_reg   <= '0;
                                max_sum_reg   <= '0;
                                vol_sum_reg   <= '0;
                                state_reg     <= pair.end_of_image ? S_FIN_GO : S_IDLE;
                            end
                            else
                            begin
                                min_sum_reg <= min_sum_next;
                                max_sum_reg <= max_sum_next;
                                vol_sum_reg <= vol_sum_next;
                                state_reg   <= S_MIN_GO;
                            end
                        end
                        else
                        begin
                            min_sum_reg <= min_sum_next;
                            max_sum_reg <= max_sum_next;
                            vol_sum_reg <= vol_sum_next;
                        end
                    end
                end
                S_MIN_GO:
                begin
                    state_reg <= S_MIN_WAIT;
                end
                S_MIN_WAIT:
                begin
                    if (div_done)
                    begin
                        wmin_reg  <= total_next;
                        state_reg <= S_MAX_GO;
                    end
                end
                S_MAX_GO:
                begin
                    state_reg <= S_MAX_WAIT;
                end
                S_MAX_WAIT:
                begin
                    if (div_done)
                    begin
                        wmax_reg    <= total_next;
                        min_sum_reg <= '0;
                        max_sum_reg <= '0;
                        vol_sum_reg <= '0;
                        state_reg   <= eoi_reg ? S_FIN_GO : S_IDLE;
                    end
                end
                S_FIN_GO:
                begin
                    state_reg <= S_FIN_WAIT;
                end
                S_FIN_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (push_ok)
                    begin
                        score_valid_reg         <= 1'b1;
                        score_reg.status        <= final_status;
                        score_reg.overlap_ratio <= (final_status == lojd_pkg::STATUS_OK)
                                                   ? div_quo[lojd_pkg::RATIO_W-1:0] : '0;
                        count_a_reg    <= '0;
                        count_b_reg    <= '0;
                        count_both_reg <= '0;
                        min_sum_reg    <= '0;
                        max_sum_reg    <= '0;
                        vol_sum_reg    <= '0;
                        wmin_reg       <= '0;
                        wmax_reg       <= '0;
                        zero_seen_reg  <= 1'b0;
                        eoi_reg        <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign score_valid = score_valid_reg;
    assign score       = score_reg;

endmodule

// File: rtl/core/lojd_checker.sv
// port-level checks for the label overlap scorer, bound to the top level
module lojd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                pair_valid,
    input logic                                pair_ready,
    input lojd_pkg::pair_t                     pair,
    input logic                                score_valid,
    input logic                                score_ready,
    input lojd_pkg::score_t                    score
);

    logic pair_take;

    assign pair_take = pair_valid && pair_ready;

    // a stalled score keeps its payload
    a_score_hold: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid && !score_ready |=> score_valid && $stable(score))
        else $error("score changed while stalled");

    // a plain pair never stalls the next request
    a_plain_pair: assert property (@(posedge clk) disable iff (!rst_n)
        pair_take && !pair.end_of_volume && !pair.end_of_image |=> pair_ready)
        else $error("stalled after a plain pair");

    // an image end always starts the final division
    a_image_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pair_take && pair.end_of_image |=> !pair_ready)
        else $error("ready right after image end");

    // an error status carries a zero ratio
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid && score.status != lojd_pkg::STATUS_OK |-> score.overlap_ratio == '0)
        else $error("nonzero ratio with error status");

    // ratio never exceeds one
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        score_valid |-> score.overlap_ratio <= 17'd65536)
        else $error("ratio above one");

endmodule

bind label_overlap_jaccard_dice_core lojd_checker u_lojd_checker (.*);

// File: dv/overlap_scoreboard_pkg.sv
// overlap score predictor and scoreboard for the label overlap scorer testbench
package overlap_scoreboard_pkg;

    import lojd_pkg::*;

    localparam int VOXEL_BITS  = 24;
    localparam int FRAME_BITS  = 8;
    localparam int COUNT_W     = VOXEL_BITS + 1;
    localparam int FRAME_SUM_W = VOXEL_BITS + SAMPLE_W;
    localparam int VOL_SUM_W   = VOXEL_BITS + SAMPLE_W + 1;
    localparam int TERM_FRAC   = 31 - FRAME_BITS;

    class overlap_scoreboard;

        logic [THRESH_W-1:0] thresh;
        logic                fuzzy;
        logic                dice;

        logic [63:0] labeled_a;
        logic [63:0] labeled_b;
        logic [63:0] labeled_both;
        logic [63:0] frame_lo;
        logic [63:0] frame_hi;
        logic [63:0] frame_vol;
        logic [63:0] lo_total;
        logic [63:0] hi_total;
        logic        empty_frame_seen;

        score_t expected_scores[$];
        int     failures;

        function new();
            thresh = THRESHOLD_RESET;
            fuzzy = 1'b0;
            dice = 1'b0;
            failures = 0;
            clear_image();
        endfunction

        function logic [63:0] clamp_add(logic [63:0] x, logic [63:0] y, int w);
            logic [63:0] top;
            top = (64'd1 << w) - 64'd1;
            if (x > top)
                x = top;
            if (y > top - x)
                return top;
            return x + y;
        endfunction

        // rounded num/den with frac_bits fraction bits, clamped to one
        function logic [63:0] round_frac(logic [63:0] num, logic [63:0] den, int frac_bits);
            logic [63:0] q;
            logic [63:0] r;
            q = 64'd0;
            r = num;
            if (den == 64'd0)
                return 64'd0;
            if (num >= den)
                return 64'd1 << frac_bits;
            for (int i = 0; i < frac_bits; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
            if ((r << 1) >= den)
                q = q + 64'd1;
            return q;
        endfunction

        function void clear_frame();
            frame_lo = 64'd0;
            frame_hi = 64'd0;
            frame_vol = 64'd0;
        endfunction

        function void clear_image();
            labeled_a = 64'd0;
            labeled_b = 64'd0;
            labeled_both = 64'd0;
            clear_frame();
            lo_total = 64'd0;
            hi_total = 64'd0;
            empty_frame_seen = 1'b0;
        endfunction

        function void fold_frame();
            if (frame_vol == 64'd0)
                empty_frame_seen = 1'b1;
            else
            begin
                lo_total = clamp_add(lo_total, round_frac(frame_lo, frame_vol, TERM_FRAC),
                                     TOTAL_W);
                hi_total = clamp_add(hi_total, round_frac(frame_hi, frame_vol, TERM_FRAC),
                                     TOTAL_W);
            end
            clear_frame();
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THRESHOLD:   thresh = data;
                REG_FUZZY_MODE:  fuzzy = data[0];
                REG_REPORT_DICE: dice = data[0];
                default: ;
            endcase
        endfunction

        function void take_pair(pair_t p);
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] both;
            logic [63:0] total;
            logic [63:0] uni;
            logic [63:0] q;
            score_t      s;
            a = {48'd0, p.sample_a};
            b = {48'd0, p.sample_b};
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (p.sample_a >= thresh)
                labeled_a = clamp_add(labeled_a, 64'd1, COUNT_W);
            if (p.sample_b >= thresh)
                labeled_b = clamp_add(labeled_b, 64'd1, COUNT_W);
            if (p.sample_a >= thresh && p.sample_b >= thresh)
                labeled_both = clamp_add(labeled_both, 64'd1, COUNT_W);
            frame_lo = clamp_add(frame_lo, lo, FRAME_SUM_W);
            frame_hi = clamp_add(frame_hi, hi, FRAME_SUM_W);
            frame_vol = clamp_add(frame_vol, a + b, VOL_SUM_W);
            if (p.end_of_volume || p.end_of_image)
                fold_frame();
            if (!p.end_of_image)
                return;
            q = 64'd0;
            s.status = STATUS_OK;
            if (fuzzy)
            begin
                if (empty_frame_seen)
                    s.status = STATUS_ZERO_VOLUME;
                else if (hi_total == 64'd0)
                    s.status = STATUS_EMPTY;
                else
                    q = round_frac(lo_total, hi_total, RATIO_F);
            end
            else
            begin
                both = labeled_both;
                if (both > labeled_a)
                    both = labeled_a;
                if (both > labeled_b)
                    both = labeled_b;
                total = labeled_a + labeled_b;
                uni = total - both;
                if (uni == 64'd0)
                    s.status = STATUS_EMPTY;
                else if (dice)
                    q = round_frac(both << 1, total, RATIO_F);
                else
                    q = round_frac(both, uni, RATIO_F);
            end
            s.overlap_ratio = q[RATIO_W-1:0];
            expected_scores.push_back(s);
            clear_image();
        endfunction

        function void check_score(score_t got);
            score_t want;
            if (expected_scores.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected score: ratio %0d status %0d",
                             got.overlap_ratio, got.status);
                return;
            end
            want = expected_scores.pop_front();
            if (got.overlap_ratio !== want.overlap_ratio || got.status !== want.status)
            begin
                failures++;
                if (failures <= 10)
                    $display("score mismatch: expected ratio %0d status %0d, got ratio %0d status %0d",
                             want.overlap_ratio, want.status, got.overlap_ratio, got.status);
            end
        endfunction

        function void finish_check();
            if (expected_scores.size() != 0)
            begin
                failures += expected_scores.size();
                $display("%0d expected scores never arrived", expected_scores.size());
            end
        endfunction

    endclass

endpackage

// File: dv/tb.sv
// testbench top: drives voxel pair requests and checks overlap scores
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lojd_pkg::*;
    import overlap_scoreboard_pkg::*;

    localparam int ITEM_TARGET   = 1350;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SAT_FRAMES    = 600;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pair_valid = 1'b0;
    logic                   pair_ready;
    pair_t                  pair = '0;
    logic                   score_valid;
    logic                   score_ready = 1'b0;
    score_t                 score;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    overlap_scoreboard sb = new();

    int sent = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int quiet_cycles = 0;

    always #5ns clk = ~clk;

    label_overlap_jaccard_dice_core #(
        .VOXEL_COUNT_BITS(VOXEL_BITS),
        .FRAME_COUNT_BITS(FRAME_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .pair_valid(pair_valid),
        .pair_ready(pair_ready),
        .pair(pair),
        .score_valid(score_valid),
        .score_ready(score_ready),
        .score(score),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // score side: stall pattern of its own, plus one long hold-off
    always @(posedge clk)
    begin
        if (score_valid === 1'b1 && score_ready)
            sb.check_score(score);
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(64, 300);
        end
        rx_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            score_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       score_ready <= 1'b1;
                1:       score_ready <= 1'($urandom_range(0, 1));
                2:       score_ready <= ($urandom_range(0, 3) == 0);
                default: score_ready <= ((rx_left % 5) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((pair_valid && pair_ready === 1'b1) || (score_valid === 1'b1 && score_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // request side: bursts of random length with random gaps
    task automatic send_pair(input pair_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                pair_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pair_valid <= 1'b1;
        pair <= p;
        @(posedge clk);
        while (pair_ready !== 1'b1)
            @(posedge clk);
        sb.take_pair(p);
        sent++;
    endtask

    task automatic offer(input logic [15:0] a, input logic [15:0] b, input bit eov, input bit eoi);
        pair_t p;
        p.sample_a = a;
        p.sample_b = b;
        p.end_of_volume = eov;
        p.end_of_image = eoi;
        send_pair(p);
    endtask

    task automatic settle();
        pair_valid <= 1'b0;
        while (sb.expected_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic load_settings(input logic [15:0] thr, input bit fz, input bit dc);
        logic [14:0] junk;
        settle();
        junk = 15'($urandom);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FUZZY_MODE, {junk, fz});
        junk = 15'($urandom);
        write_reg(REG_REPORT_DICE, {junk, dc});
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] t;
        t = sb.thresh;
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return t;
            3:       return t - 16'd1;
            4, 5:    return 16'($urandom_range(int'(t), 65535));
            6, 7:    return (t == 16'd0) ? 16'($urandom) : 16'($urandom_range(0, int'(t) - 1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_image(input int len);
        logic [15:0] a;
        logic [15:0] b;
        bit          eov;
        bit          blank;
        bit          fresh;
        fresh = 1'b1;
        blank = 1'b0;
        for (int i = 0; i < len; i++)
        begin
            if (fresh)
                blank = ($urandom_range(0, 9) == 0);
            a = blank ? 16'd0 : pick_sample();
            b = blank ? 16'd0 : (($urandom_range(0, 3) == 0) ? a : pick_sample());
            eov = (i == len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
            offer(a, b, eov, i == len - 1);
            fresh = eov;
        end
    endtask

    // many single-pair frames so the fuzzy totals saturate
    task automatic send_saturating_image();
        logic [15:0] x;
        for (int i = 0; i < SAT_FRAMES; i++)
        begin
            x = 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 4) == 0)
                offer(x, x, 1'b1, i == SAT_FRAMES - 1);
            else if ($urandom_range(0, 1) == 0)
                offer(x, 16'd0, 1'b1, i == SAT_FRAMES - 1);
            else
                offer(16'd0, x, 1'b1, i == SAT_FRAMES - 1);
        end
    endtask

    initial
    begin
        int          phase;
        int          budget;
        logic [15:0] thr;
        bit          fz;
        bit          dc;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: hard jaccard at mid threshold
        offer(16'd0, 16'd0, 1'b0, 1'b1);
        offer(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        offer(16'd32768, 16'd32767, 1'b0, 1'b1);
        offer(16'd40000, 16'd40000, 1'b0, 1'b0);
        offer(16'd40000, 16'd0, 1'b1, 1'b0);
        offer(16'd0, 16'd40000, 1'b0, 1'b1);

        load_settings(16'd32768, 1'b0, 1'b1);
        offer(16'd40000, 16'd40000, 1'b0, 1'b0);
        offer(16'd40000, 16'd0, 1'b1, 1'b0);
        offer(16'd0, 16'd40000, 1'b0, 1'b1);
        offer(16'd0, 16'd0, 1'b1, 1'b1);

        load_settings(16'd0, 1'b0, 1'b0);
        offer(16'd0, 16'd0, 1'b0, 1'b1);
        offer(16'd12345, 16'd0, 1'b1, 1'b1);

        load_settings(16'hFFFF, 1'b0, 1'b1);
        offer(16'hFFFF, 16'hFFFE, 1'b0, 1'b1);
        offer(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);

        // fuzzy: zero-volume frames, mixed frames, full overlap
        load_settings(16'd32768, 1'b1, 1'b0);
        offer(16'd0, 16'd0, 1'b1, 1'b0);
        offer(16'd100, 16'd50, 1'b0, 1'b1);
        offer(16'd0, 16'd0, 1'b0, 1'b1);
        offer(16'hFFFF, 16'd0, 1'b1, 1'b0);
        offer(16'd100, 16'd300, 1'b0, 1'b1);
        offer(16'd7, 16'd7, 1'b1, 1'b1);

        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            case (phase % 5)
                0:       thr = 16'd0;
                1:       thr = 16'hFFFF;
                2:       thr = 16'd32768;
                default: thr = 16'($urandom);
            endcase
            fz = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            dc = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
            if (phase == 3)
            begin
                load_settings(thr, 1'b1, dc);
                send_saturating_image();
            end
            else
            begin
                load_settings(thr, fz, dc);
                if (phase == 2)
                    hold_req = 1'b1;
                budget = sent + $urandom_range(60, 140);
                while (sent < budget && sent < ITEM_TARGET)
                    send_image(($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                           : $urandom_range(1, 12));
            end
            phase++;
        end

        settle();
        sb.finish_check();
        if (sb.failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lojd_pkg.sv
rtl/core/lojd_div.sv
rtl/core/label_overlap_jaccard_dice_core.sv
rtl/core/lojd_checker.sv
dv/overlap_scoreboard_pkg.sv
dv/tb.sv
